@@ rtl/core/acet_pkg.sv @@
// ----------------------------------------------------------------------------
// acet_pkg
// Shared sizes, command and status codes, slot layout and coordinate helpers
// for the box collision table.
// ----------------------------------------------------------------------------
package acet_pkg;

	localparam int MAX_ENTITIES = 64;
	localparam int COORD_WIDTH  = 16;

	localparam int IDX_W   = $clog2(MAX_ENTITIES);
	localparam int CNT_W   = $clog2(MAX_ENTITIES + 1);
	localparam int ID_W    = 32;
	localparam int BOX_W   = 16;
	localparam int HIT_W   = 6;
	localparam int EXT_W   = ((COORD_WIDTH > BOX_W) ? COORD_WIDTH : BOX_W) + 2;
	localparam int ENTRY_W = ID_W + 2 * COORD_WIDTH + 4 * BOX_W;

	localparam logic [2:0] CMD_INSERT  = 3'd0;
	localparam logic [2:0] CMD_DESTROY = 3'd1;
	localparam logic [2:0] CMD_SETPOS  = 3'd2;
	localparam logic [2:0] CMD_POINT   = 3'd3;
	localparam logic [2:0] CMD_FIND    = 3'd4;
	localparam logic [2:0] CMD_BOX     = 3'd5;
	localparam logic [2:0] CMD_COMPACT = 3'd6;
	localparam logic [2:0] CMD_CLEAR   = 3'd7;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_MISS = 2'd1;
	localparam logic [1:0] STS_FULL = 2'd2;
	localparam logic [1:0] STS_NONE = 2'd3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [BOX_W-1:0]       boxv_t;
	typedef logic signed [EXT_W-1:0]       ext_t;

	typedef struct packed {
		logic [ID_W-1:0] ident;
		coord_t          pos_x;
		coord_t          pos_y;
		boxv_t           off_x;
		boxv_t           off_y;
		boxv_t           wid;
		boxv_t           hgt;
	} entry_t;

	// Sign-extend a 16-bit field, then wrap it to the coordinate width.
	function automatic coord_t to_coord(input logic [15:0] raw);
		logic signed [31:0] wide;
		wide = signed'(raw);
		return wide[COORD_WIDTH-1:0];
	endfunction

	function automatic boxv_t to_box(input logic [15:0] raw);
		coord_t             c;
		logic signed [31:0] wide;
		c    = to_coord(raw);
		wide = c;
		return wide[BOX_W-1:0];
	endfunction

	function automatic ext_t ext_pos(input coord_t v);
		ext_t e;
		e = v;
		return e;
	endfunction

	function automatic ext_t ext_box(input boxv_t v);
		ext_t e;
		e = v;
		return e;
	endfunction

endpackage

@@ rtl/core/acet_req_if.sv @@
// ----------------------------------------------------------------------------
// acet_req_if
// Command channel: valid/ready handshake with one command per beat.
// ----------------------------------------------------------------------------
interface acet_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] target_id;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [15:0] box_off_x;
	logic [15:0] box_off_y;
	logic [15:0] box_width;
	logic [15:0] box_height;

	modport source (output valid, cmd, target_id, pos_x, pos_y, box_off_x, box_off_y,
		box_width, box_height, input ready);
	modport sink (input valid, cmd, target_id, pos_x, pos_y, box_off_x, box_off_y,
		box_width, box_height, output ready);
endinterface

@@ rtl/core/acet_rsp_if.sv @@
// ----------------------------------------------------------------------------
// acet_rsp_if
// Result channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface acet_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] hit_id;
	logic [5:0]  hit_count;
	logic        last;

	modport source (output valid, status, hit_id, hit_count, last, input ready);
	modport sink (input valid, status, hit_id, hit_count, last, output ready);
endinterface

@@ rtl/core/acet_ram.sv @@
// ----------------------------------------------------------------------------
// acet_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module acet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/aabb_entity_collision_table.sv @@
// ----------------------------------------------------------------------------
// aabb_entity_collision_table
// Ordered table of axis-aligned boxes with insert, destroy, set position,
// point query, find, box query, compact and clear commands.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  req     | in  | cmd, target_id, pos_x, pos_y, box_off_x/y, box_width/height
//  rsp     | out | status, hit_id, hit_count, last
//
//  Insert and clear need no slot walk: the accept is followed by the result beat.
//  Every other command walks the slot RAM through its single read port, one
//  slot per cycle while rsp does not stall, behind the registered RAM read
//  and the corner registers; an id match or point hit ends the walk early,
//  and a box query walks twice once its entity is found.
//  A stalled rsp holds the box query scan, which restarts at the stalled slot.
//  Reset clears the live bits, the fill count and the id counter at once.
//  req is ready only while no command is in progress.
// ----------------------------------------------------------------------------
module aabb_entity_collision_table (
	input logic       clk,
	input logic       arst_n,
	acet_req_if.sink  req,
	acet_rsp_if.source rsp
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} state_t;

	state_t                             state_q;
	logic [acet_pkg::MAX_ENTITIES-1:0]  live_q;
	logic [acet_pkg::CNT_W-1:0]         fill_end_q;
	logic [acet_pkg::ID_W-1:0]          next_id_q;

	logic [2:0]                         cmd_q;
	logic [acet_pkg::ID_W-1:0]          tid_q;
	acet_pkg::coord_t                   px_q, py_q;
	logic                               phase2_q;
	logic [acet_pkg::IDX_W-1:0]         slot_q;
	acet_pkg::ext_t                     ax0_q, ay0_q, ax1_q, ay1_q;
	logic [acet_pkg::CNT_W-1:0]         scan_a_q;
	logic [acet_pkg::CNT_W-1:0]         w_q;
	logic                               pend_q;
	logic [acet_pkg::ID_W-1:0]          pend_id_q;
	logic [acet_pkg::HIT_W-1:0]         cnt_q;

	logic [1:0]                         res_status_q;
	logic [acet_pkg::ID_W-1:0]          res_id_q;
	logic [acet_pkg::HIT_W-1:0]         res_cnt_q;

	logic                               out_valid_q;
	logic [1:0]                         out_status_q;
	logic [acet_pkg::ID_W-1:0]          out_id_q;
	logic [acet_pkg::HIT_W-1:0]         out_cnt_q;
	logic                               out_last_q;

	logic                               v_s1;
	logic [acet_pkg::IDX_W-1:0]         idx_s1;
	logic                               v_s2, live_s2;
	logic [acet_pkg::IDX_W-1:0]         idx_s2;
	acet_pkg::entry_t                   data_s2;
	acet_pkg::ext_t                     x0_s2, y0_s2, x1_s2, y1_s2;

	logic                               wr_en;
	logic [acet_pkg::IDX_W-1:0]         wr_addr;
	acet_pkg::entry_t                   wr_data;
	logic [acet_pkg::ENTRY_W-1:0]       rd_raw;
	acet_pkg::entry_t                   rd_ent;
	acet_pkg::ext_t                     x0_c, y0_c, x1_c, y1_c;
	acet_pkg::ext_t                     px_e, py_e;

	logic accept, issue, out_free, scan_done, full;
	logic find_op, id_match, pt_hit, bx_hit, cpy_live;

	acet_ram #(
		.WIDTH (acet_pkg::ENTRY_W),
		.DEPTH (acet_pkg::MAX_ENTITIES)
	) u_slots (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (scan_a_q[acet_pkg::IDX_W-1:0]),
		.rdata (rd_raw)
	);

	assign req.ready     = (state_q == S_IDLE);
	assign accept        = req.valid && req.ready;
	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.hit_id    = out_id_q;
	assign rsp.hit_count = out_cnt_q;
	assign rsp.last      = out_last_q;

	assign out_free  = !out_valid_q || rsp.ready;
	assign full      = (fill_end_q == acet_pkg::CNT_W'(acet_pkg::MAX_ENTITIES));
	assign issue     = (state_q == S_SCAN) && (scan_a_q < fill_end_q);
	assign scan_done = (state_q == S_SCAN) && !v_s1 && !v_s2 && (scan_a_q >= fill_end_q);

	assign find_op = (cmd_q == acet_pkg::CMD_DESTROY) || (cmd_q == acet_pkg::CMD_SETPOS) ||
		(cmd_q == acet_pkg::CMD_FIND) || ((cmd_q == acet_pkg::CMD_BOX) && !phase2_q);

	// Box corners for the slot coming out of the RAM.
	always_comb begin
		rd_ent = acet_pkg::entry_t'(rd_raw);
		x0_c   = acet_pkg::ext_pos(rd_ent.pos_x) + acet_pkg::ext_box(rd_ent.off_x);
		y0_c   = acet_pkg::ext_pos(rd_ent.pos_y) + acet_pkg::ext_box(rd_ent.off_y);
		x1_c   = x0_c + acet_pkg::ext_box(rd_ent.wid);
		y1_c   = y0_c + acet_pkg::ext_box(rd_ent.hgt);
		px_e   = acet_pkg::ext_pos(px_q);
		py_e   = acet_pkg::ext_pos(py_q);
	end

	assign id_match = v_s2 && live_s2 && (data_s2.ident == tid_q);
	assign pt_hit   = v_s2 && live_s2 && (x0_s2 < px_e) && (x1_s2 > px_e) &&
		(y0_s2 < py_e) && (y1_s2 > py_e);
	assign bx_hit   = v_s2 && live_s2 && (idx_s2 != slot_q) && (x0_s2 < ax1_q) &&
		(x1_s2 > ax0_q) && (y0_s2 < ay1_q) && (y1_s2 > ay0_q);
	assign cpy_live = v_s2 && live_s2;

	// Slot writes: insert, set position, compaction moves.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s2;
		wr_data = data_s2;
		if (accept && (req.cmd == acet_pkg::CMD_INSERT) && !full) begin
			wr_en         = 1'b1;
			wr_addr       = fill_end_q[acet_pkg::IDX_W-1:0];
			wr_data.ident = next_id_q;
			wr_data.pos_x = acet_pkg::to_coord(req.pos_x);
			wr_data.pos_y = acet_pkg::to_coord(req.pos_y);
			wr_data.off_x = acet_pkg::to_box(req.box_off_x);
			wr_data.off_y = acet_pkg::to_box(req.box_off_y);
			wr_data.wid   = acet_pkg::to_box(req.box_width);
			wr_data.hgt   = acet_pkg::to_box(req.box_height);
		end else if (state_q == S_SCAN && cmd_q == acet_pkg::CMD_SETPOS && id_match) begin
			wr_en         = 1'b1;
			wr_data.pos_x = px_q;
			wr_data.pos_y = py_q;
		end else if (state_q == S_SCAN && cmd_q == acet_pkg::CMD_COMPACT && cpy_live &&
			(w_q[acet_pkg::IDX_W-1:0] != idx_s2)) begin
			wr_en   = 1'b1;
			wr_addr = w_q[acet_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		data_s2 <= rd_ent;
		x0_s2   <= x0_c;
		y0_s2   <= y0_c;
		x1_s2   <= x1_c;
		y1_s2   <= y1_c;
		idx_s2  <= idx_s1;
		live_s2 <= live_q[idx_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			live_q       <= '0;
			fill_end_q   <= '0;
			next_id_q    <= '0;
			out_valid_q  <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			idx_s1       <= '0;
			scan_a_q     <= '0;
			w_q          <= '0;
			pend_q       <= 1'b0;
			phase2_q     <= 1'b0;
			cnt_q        <= '0;
			cmd_q        <= acet_pkg::CMD_INSERT;
			tid_q        <= '0;
			px_q         <= '0;
			py_q         <= '0;
			slot_q       <= '0;
			ax0_q        <= '0;
			ay0_q        <= '0;
			ax1_q        <= '0;
			ay1_q        <= '0;
			pend_id_q    <= '0;
			res_status_q <= acet_pkg::STS_OK;
			res_id_q     <= '0;
			res_cnt_q    <= '0;
			out_status_q <= acet_pkg::STS_OK;
			out_id_q     <= '0;
			out_cnt_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q     <= req.cmd;
						tid_q     <= req.target_id;
						px_q      <= acet_pkg::to_coord(req.pos_x);
						py_q      <= acet_pkg::to_coord(req.pos_y);
						scan_a_q  <= '0;
						w_q       <= '0;
						pend_q    <= 1'b0;
						cnt_q     <= '0;
						phase2_q  <= 1'b0;
						v_s1      <= 1'b0;
						v_s2      <= 1'b0;
						res_cnt_q <= '0;
						res_id_q  <= '0;
						res_status_q <= acet_pkg::STS_OK;
						unique case (req.cmd)
							acet_pkg::CMD_INSERT: begin
								state_q <= S_RESP;
								if (full) begin
									res_status_q <= acet_pkg::STS_FULL;
								end else begin
									live_q[fill_end_q[acet_pkg::IDX_W-1:0]] <= 1'b1;
									res_id_q   <= next_id_q;
									next_id_q  <= next_id_q + 1'b1;
									fill_end_q <= fill_end_q + 1'b1;
								end
							end
							acet_pkg::CMD_CLEAR: begin
								state_q    <= S_RESP;
								live_q     <= '0;
								fill_end_q <= '0;
								next_id_q  <= '0;
							end
							default: begin
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					// Advance the read and corner pipeline.
					v_s2 <= v_s1;
					v_s1 <= issue;
					if (issue) begin
						idx_s1   <= scan_a_q[acet_pkg::IDX_W-1:0];
						scan_a_q <= scan_a_q + 1'b1;
					end
					if (scan_done) begin
						state_q      <= S_RESP;
						res_status_q <= acet_pkg::STS_MISS;
						if (cmd_q == acet_pkg::CMD_COMPACT) begin
							fill_end_q   <= w_q;
							res_status_q <= acet_pkg::STS_OK;
						end else if (cmd_q == acet_pkg::CMD_BOX && phase2_q) begin
							if (pend_q) begin
								res_status_q <= acet_pkg::STS_OK;
								res_id_q     <= pend_id_q;
								res_cnt_q    <= cnt_q;
							end else begin
								res_status_q <= acet_pkg::STS_NONE;
							end
						end
					end else if (find_op) begin
						if (id_match) begin
							v_s1 <= 1'b0;
							v_s2 <= 1'b0;
							if (cmd_q == acet_pkg::CMD_BOX) begin
								// Entity found: rescan all slots against its box.
								phase2_q <= 1'b1;
								slot_q   <= idx_s2;
								ax0_q    <= x0_s2;
								ay0_q    <= y0_s2;
								ax1_q    <= x1_s2;
								ay1_q    <= y1_s2;
								scan_a_q <= '0;
							end else begin
								if (cmd_q == acet_pkg::CMD_DESTROY) begin
									live_q[idx_s2] <= 1'b0;
								end
								state_q      <= S_RESP;
								res_status_q <= acet_pkg::STS_OK;
								res_id_q     <= tid_q;
							end
						end
					end else if (cmd_q == acet_pkg::CMD_POINT) begin
						if (pt_hit) begin
							v_s1         <= 1'b0;
							v_s2         <= 1'b0;
							state_q      <= S_RESP;
							res_status_q <= acet_pkg::STS_OK;
							res_id_q     <= data_s2.ident;
						end
					end else if (cmd_q == acet_pkg::CMD_BOX) begin
						// Hold one hit back so the final one can carry last.
						if (bx_hit) begin
							if (!pend_q) begin
								pend_q    <= 1'b1;
								pend_id_q <= data_s2.ident;
								cnt_q     <= acet_pkg::HIT_W'(1);
							end else if (out_free) begin
								out_valid_q  <= 1'b1;
								out_status_q <= acet_pkg::STS_OK;
								out_id_q     <= pend_id_q;
								out_cnt_q    <= cnt_q;
								out_last_q   <= 1'b0;
								pend_id_q    <= data_s2.ident;
								cnt_q        <= cnt_q + 1'b1;
							end else begin
								// Output stalled: drop in-flight reads, retry this slot.
								v_s1     <= 1'b0;
								v_s2     <= 1'b0;
								scan_a_q <= {1'b0, idx_s2};
							end
						end
					end else if (cmd_q == acet_pkg::CMD_COMPACT) begin
						if (cpy_live) begin
							w_q <= w_q + 1'b1;
							if (w_q[acet_pkg::IDX_W-1:0] != idx_s2) begin
								live_q[w_q[acet_pkg::IDX_W-1:0]] <= 1'b1;
								live_q[idx_s2]                    <= 1'b0;
							end
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_id_q     <= res_id_q;
						out_cnt_q    <= res_cnt_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ test/aabb_entity_collision_table_tb.sv @@
// ----------------------------------------------------------------------------
// aabb_entity_collision_table_tb
// Drives command beats into the box collision table, predicts every result
// with a behavioral copy of the table and checks each result beat in order.
// ----------------------------------------------------------------------------
module aabb_entity_collision_table_tb;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] hit_id;
		logic [5:0]  hit_count;
		logic        last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	acet_req_if req ();
	acet_rsp_if rsp ();

	aabb_entity_collision_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// behavioral table
	logic               tbl_live [acet_pkg::MAX_ENTITIES];
	logic [31:0]        tbl_id   [acet_pkg::MAX_ENTITIES];
	logic signed [15:0] tbl_px   [acet_pkg::MAX_ENTITIES];
	logic signed [15:0] tbl_py   [acet_pkg::MAX_ENTITIES];
	logic signed [15:0] tbl_ox   [acet_pkg::MAX_ENTITIES];
	logic signed [15:0] tbl_oy   [acet_pkg::MAX_ENTITIES];
	logic signed [15:0] tbl_w    [acet_pkg::MAX_ENTITIES];
	logic signed [15:0] tbl_h    [acet_pkg::MAX_ENTITIES];
	int                 tbl_fill;
	logic [31:0]        tbl_next;

	result_t pending_results [$];
	int      error_count = 0;
	bit      idle_on = 1'b1;

	function automatic void corners_of(input int i, output longint x0, output longint y0,
		output longint x1, output longint y1);
		x0 = longint'(tbl_px[i]) + longint'(tbl_ox[i]);
		y0 = longint'(tbl_py[i]) + longint'(tbl_oy[i]);
		x1 = x0 + longint'(tbl_w[i]);
		y1 = y0 + longint'(tbl_h[i]);
	endfunction

	function automatic int slot_of(input logic [31:0] id);
		for (int i = 0; i < tbl_fill; i++)
			if (tbl_live[i] && tbl_id[i] == id) return i;
		return -1;
	endfunction

	function automatic result_t mk(input logic [1:0] st, input logic [31:0] id,
		input logic [5:0] cnt, input logic lst);
		result_t r;
		r.status = st; r.hit_id = id; r.hit_count = cnt; r.last = lst;
		return r;
	endfunction

	function automatic void expect_beat(input result_t r);
		pending_results = {pending_results, r};
	endfunction

	function automatic void predict_table(input logic [2:0] cmd, input logic [31:0] tid,
		input logic signed [15:0] px, input logic signed [15:0] py,
		input logic signed [15:0] ox, input logic signed [15:0] oy,
		input logic signed [15:0] bw, input logic signed [15:0] bh);
		int s;
		int w;
		int n;
		longint ax0, ay0, ax1, ay1, x0, y0, x1, y1;
		result_t hits [$];
		case (cmd)
			acet_pkg::CMD_INSERT: begin
				if (tbl_fill >= acet_pkg::MAX_ENTITIES) begin
					expect_beat(mk(acet_pkg::STS_FULL, 32'd0, 6'd0, 1'b1));
				end else begin
					tbl_live[tbl_fill] = 1'b1; tbl_id[tbl_fill] = tbl_next;
					tbl_px[tbl_fill] = px; tbl_py[tbl_fill] = py;
					tbl_ox[tbl_fill] = ox; tbl_oy[tbl_fill] = oy;
					tbl_w[tbl_fill] = bw; tbl_h[tbl_fill] = bh;
					expect_beat(mk(acet_pkg::STS_OK, tbl_next, 6'd0, 1'b1));
					tbl_next++;
					tbl_fill++;
				end
			end
			acet_pkg::CMD_DESTROY, acet_pkg::CMD_SETPOS, acet_pkg::CMD_FIND: begin
				s = slot_of(tid);
				if (s < 0) begin
					expect_beat(mk(acet_pkg::STS_MISS, 32'd0, 6'd0, 1'b1));
				end else begin
					if (cmd == acet_pkg::CMD_DESTROY) tbl_live[s] = 1'b0;
					if (cmd == acet_pkg::CMD_SETPOS) begin
						tbl_px[s] = px; tbl_py[s] = py;
					end
					expect_beat(mk(acet_pkg::STS_OK, tid, 6'd0, 1'b1));
				end
			end
			acet_pkg::CMD_POINT: begin
				s = -1;
				for (int i = 0; i < tbl_fill && s < 0; i++) begin
					if (tbl_live[i]) begin
						corners_of(i, x0, y0, x1, y1);
						if (x0 < px && x1 > px && y0 < py && y1 > py) s = i;
					end
				end
				if (s < 0) expect_beat(mk(acet_pkg::STS_MISS, 32'd0, 6'd0, 1'b1));
				else expect_beat(mk(acet_pkg::STS_OK, tbl_id[s], 6'd0, 1'b1));
			end
			acet_pkg::CMD_BOX: begin
				s = slot_of(tid);
				if (s < 0) begin
					expect_beat(mk(acet_pkg::STS_MISS, 32'd0, 6'd0, 1'b1));
				end else begin
					corners_of(s, ax0, ay0, ax1, ay1);
					n = 0;
					for (int i = 0; i < tbl_fill; i++) begin
						if (tbl_live[i] && i != s) begin
							corners_of(i, x0, y0, x1, y1);
							if (x0 < ax1 && x1 > ax0 && y0 < ay1 && y1 > ay0) begin
								n++;
								hits = {hits, mk(acet_pkg::STS_OK, tbl_id[i], n[5:0], 1'b0)};
							end
						end
					end
					if (n == 0) begin
						expect_beat(mk(acet_pkg::STS_NONE, 32'd0, 6'd0, 1'b1));
					end else begin
						hits[n-1].last = 1'b1;
						foreach (hits[k]) expect_beat(hits[k]);
					end
				end
			end
			acet_pkg::CMD_COMPACT: begin
				w = 0;
				for (int i = 0; i < tbl_fill; i++) begin
					if (tbl_live[i]) begin
						if (w != i) begin
							tbl_id[w] = tbl_id[i]; tbl_px[w] = tbl_px[i];
							tbl_py[w] = tbl_py[i]; tbl_ox[w] = tbl_ox[i];
							tbl_oy[w] = tbl_oy[i]; tbl_w[w] = tbl_w[i];
							tbl_h[w] = tbl_h[i];
							tbl_live[w] = 1'b1; tbl_live[i] = 1'b0;
						end
						w++;
					end
				end
				tbl_fill = w;
				expect_beat(mk(acet_pkg::STS_OK, 32'd0, 6'd0, 1'b1));
			end
			default: begin
				foreach (tbl_live[i]) tbl_live[i] = 1'b0;
				tbl_fill = 0;
				tbl_next = 0;
				expect_beat(mk(acet_pkg::STS_OK, 32'd0, 6'd0, 1'b1));
			end
		endcase
	endfunction

	// drop valid only ahead of a gap; back-to-back beats keep it high
	task automatic idle_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic send_command(input logic [2:0] cmd, input logic [31:0] tid,
		input logic [15:0] px, input logic [15:0] py, input logic [15:0] ox,
		input logic [15:0] oy, input logic [15:0] bw, input logic [15:0] bh);
		req.valid <= 1'b1;
		req.cmd <= cmd; req.target_id <= tid;
		req.pos_x <= px; req.pos_y <= py;
		req.box_off_x <= ox; req.box_off_y <= oy;
		req.box_width <= bw; req.box_height <= bh;
		do @(posedge clk); while (!req.ready);
		predict_table(cmd, tid, px, py, ox, oy, bw, bh);
		idle_gap();
	endtask

	task automatic send_simple(input logic [2:0] cmd, input logic [31:0] tid,
		input logic [15:0] px, input logic [15:0] py);
		send_command(cmd, tid, px, py, 16'd0, 16'd0, 16'd0, 16'd0);
	endtask

	task automatic insert_box(input logic [15:0] px, input logic [15:0] py,
		input logic [15:0] ox, input logic [15:0] oy, input logic [15:0] bw,
		input logic [15:0] bh);
		send_command(acet_pkg::CMD_INSERT, 32'd0, px, py, ox, oy, bw, bh);
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// result checker
	always @(posedge clk) begin
		result_t exp_r;
		if (rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat status=%0d hit_id=%0h", rsp.status, rsp.hit_id);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, rsp.status);
					error_count++;
				end
				if (rsp.hit_id !== exp_r.hit_id) begin
					$error("hit_id: expected %0h, got %0h", exp_r.hit_id, rsp.hit_id);
					error_count++;
				end
				if (rsp.hit_count !== exp_r.hit_count) begin
					$error("hit_count: expected %0d, got %0d", exp_r.hit_count, rsp.hit_count);
					error_count++;
				end
				if (rsp.last !== exp_r.last) begin
					$error("last: expected %0d, got %0d", exp_r.last, rsp.last);
					error_count++;
				end
			end
		end
	end

	// result side backpressure
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	task automatic test_basic_ops();
		insert_box(16'sd0, 16'sd0, -16'sd16, -16'sd16, 16'sd32, 16'sd32);
		insert_box(16'sd8, 16'sd8, -16'sd16, -16'sd16, 16'sd32, 16'sd32);
		insert_box(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		insert_box(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		insert_box(16'sd100, 16'sd100, 16'sd0, 16'sd0, -16'sd50, -16'sd50);
		insert_box(16'sd500, 16'sd500, 16'sd0, 16'sd0, 16'sd10, 16'sd10);
		send_simple(acet_pkg::CMD_POINT, 32'd0, 16'sd1, 16'sd1);
		send_simple(acet_pkg::CMD_POINT, 32'd0, -16'sd16, 16'sd0);
		send_simple(acet_pkg::CMD_POINT, 32'd0, 16'sh8000, 16'sh8000);
		send_simple(acet_pkg::CMD_FIND, 32'd1, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_FIND, 32'hffffffff, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_BOX, 32'd0, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_BOX, 32'd5, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_BOX, 32'd4, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_BOX, 32'd77, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_SETPOS, 32'd5, 16'sd4, 16'sd4);
		send_simple(acet_pkg::CMD_SETPOS, 32'd99, 16'sd4, 16'sd4);
		send_simple(acet_pkg::CMD_BOX, 32'd5, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_DESTROY, 32'd1, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_DESTROY, 32'd1, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_BOX, 32'd0, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_COMPACT, 32'd0, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_BOX, 32'd0, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_CLEAR, 32'd0, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_FIND, 32'd0, 16'd0, 16'd0);
	endtask

	task automatic test_table_full();
		// duplicate ids after clear, then fill to the limit
		insert_box(16'd0, 16'd0, -16'sd8, -16'sd8, 16'sd16, 16'sd16);
		send_simple(acet_pkg::CMD_CLEAR, 32'd0, 16'd0, 16'd0);
		for (int i = 0; i < acet_pkg::MAX_ENTITIES; i++)
			insert_box(16'($urandom_range(0, 64)), 16'($urandom_range(0, 64)),
				-16'sd8, -16'sd8, 16'sd20, 16'sd20);
		send_simple(acet_pkg::CMD_DESTROY, 32'd3, 16'd0, 16'd0);
		insert_box(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_BOX, 32'd10, 16'd0, 16'd0);
		drain_results();
		send_simple(acet_pkg::CMD_COMPACT, 32'd0, 16'd0, 16'd0);
		insert_box(16'sd30, 16'sd30, -16'sd8, -16'sd8, 16'sd16, 16'sd16);
		insert_box(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_BOX, 32'd64, 16'd0, 16'd0);
		send_simple(acet_pkg::CMD_CLEAR, 32'd0, 16'd0, 16'd0);
	endtask

	task automatic test_random_mix(input int count);
		logic [2:0]  cmd;
		logic [31:0] tid;
		int          r;
		for (int n = 0; n < count; n++) begin
			if (n == count * 3 / 4) idle_on = 1'b0;
			r = $urandom_range(0, 99);
			if (r < 30) cmd = acet_pkg::CMD_INSERT;
			else if (r < 40) cmd = acet_pkg::CMD_DESTROY;
			else if (r < 48) cmd = acet_pkg::CMD_SETPOS;
			else if (r < 60) cmd = acet_pkg::CMD_POINT;
			else if (r < 70) cmd = acet_pkg::CMD_FIND;
			else if (r < 90) cmd = acet_pkg::CMD_BOX;
			else if (r < 96) cmd = acet_pkg::CMD_COMPACT;
			else cmd = acet_pkg::CMD_CLEAR;
			// mostly ids that exist, sometimes anything
			tid = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, tbl_next + 1);
			if ($urandom_range(0, 9) == 0)
				send_command(cmd, tid, 16'($urandom()), 16'($urandom()), 16'($urandom()),
					16'($urandom()), 16'($urandom()), 16'($urandom()));
			else
				send_command(cmd, tid, 16'($urandom_range(0, 255)),
					16'($urandom_range(0, 255)),
					16'(-$urandom_range(0, 40)), 16'(-$urandom_range(0, 40)),
					16'($urandom_range(0, 80) - 8), 16'($urandom_range(0, 80) - 8));
			if (n == count / 2) drain_results();
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.cmd = acet_pkg::CMD_INSERT;
		req.target_id = '0;
		req.pos_x = '0; req.pos_y = '0;
		req.box_off_x = '0; req.box_off_y = '0;
		req.box_width = '0; req.box_height = '0;
		foreach (tbl_live[i]) tbl_live[i] = 1'b0;
		tbl_fill = 0;
		tbl_next = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_table_full();
		test_random_mix(300);
		drain_results();
		repeat (200) @(posedge clk);
		if (error_count == 0) $display("aabb_entity_collision_table_tb: done, clean");
		else $display("aabb_entity_collision_table_tb: done, errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("aabb_entity_collision_table_tb: done, errors");
		$finish;
	end

endmodule
